// ===== design/esw_pkg.sv =====
// ----------------------------------------------------------------------------
// esw_pkg: shared types and helpers of the escalating stall watchdog
// Event codes, threshold limits, payload structs and the threshold clamp.
// ----------------------------------------------------------------------------
package esw_pkg;

  localparam int unsigned ThrW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ThrW-1:0] ThrMin = 16'd120;
  localparam logic [ThrW-1:0] ThrMax = 16'd60000;

  localparam logic [ThrW-1:0] ReportRst = 16'd400;
  localparam logic [ThrW-1:0] SevereRst = 16'd5000;
  localparam logic [ThrW-1:0] TraceRst  = 16'd2000;

  typedef enum logic [1:0] {
    KIND_BEAT   = 2'd0,
    KIND_SHOWN  = 2'd1,
    KIND_SAMPLE = 2'd2
  } esw_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REPORT = 2'd0,
    REG_SEVERE = 2'd1,
    REG_TRACE  = 2'd2
  } esw_reg_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TimeW-1:0] now_ms;
  } esw_in_t;

  typedef struct packed {
    logic             reported;
    logic [TimeW-1:0] stall_age_ms;
    logic             is_severe;
    logic             trace_due;
    logic [TimeW-1:0] stall_total;
    logic [TimeW-1:0] severe_total;
    logic [TimeW-1:0] worst_age_ms;
    logic             worst_before_window;
    logic             window_is_shown;
  } esw_out_t;

  // Effective thresholds, already clamped
  typedef struct packed {
    logic [ThrW-1:0] report;
    logic [ThrW-1:0] severe;
    logic [ThrW-1:0] trace;
  } esw_thr_t;

  function automatic logic [ThrW-1:0] clamp_thr(input logic [ThrW-1:0] v);
    logic [ThrW-1:0] r;
    if (v < ThrMin) begin
      r = ThrMin;
    end else if (v > ThrMax) begin
      r = ThrMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/esw_if.sv =====
// ----------------------------------------------------------------------------
// esw_if: request channels of the escalating stall watchdog
// One interface for incoming events and one for stall reports.
// ----------------------------------------------------------------------------
interface esw_in_if;
  import esw_pkg::*;
  logic    valid;
  logic    ready;
  esw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esw_out_if;
  import esw_pkg::*;
  logic     valid;
  logic     ready;
  esw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/esw_cfg.sv =====
// ----------------------------------------------------------------------------
// esw_cfg: threshold registers
// Holds the three threshold registers and drives their clamped values.
// ----------------------------------------------------------------------------
module esw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [esw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [esw_pkg::ThrW-1:0]      cfg_wdata_i,
  output esw_pkg::esw_thr_t             thr_o
);
  import esw_pkg::*;

  logic [ThrW-1:0] report_q, severe_q, trace_q;
  logic [ThrW-1:0] report_eff;
  logic [ThrW-1:0] trace_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q <= ReportRst;
      severe_q <= SevereRst;
      trace_q  <= TraceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REPORT: report_q <= cfg_wdata_i;
        REG_SEVERE: severe_q <= cfg_wdata_i;
        REG_TRACE:  trace_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Trace threshold never sits below the report threshold
  always_comb begin
    report_eff   = clamp_thr(report_q);
    trace_eff    = clamp_thr(trace_q);
    thr_o.report = report_eff;
    thr_o.severe = clamp_thr(severe_q);
    thr_o.trace  = (trace_eff > report_eff) ? trace_eff : report_eff;
  end

endmodule

// ===== design/esw_core.sv =====
// ----------------------------------------------------------------------------
// esw_core: watchdog state and per-event update
// Holds the episode state and computes one result per event in one pass.
// ----------------------------------------------------------------------------
module esw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  esw_pkg::esw_in_t    item_i,
  input  esw_pkg::esw_thr_t   thr_i,
  output esw_pkg::esw_out_t   res_o
);
  import esw_pkg::*;

  logic [TimeW-1:0] last_beat_q, last_beat_d;
  logic             fresh_q, fresh_d;
  logic [TimeW-1:0] next_rep_q, next_rep_d;
  logic             stall_cnt_q, stall_cnt_d;
  logic             sev_cnt_q, sev_cnt_d;
  logic [TimeW-1:0] stall_tot_q, stall_tot_d;
  logic [TimeW-1:0] sev_tot_q, sev_tot_d;
  logic [TimeW-1:0] worst_q, worst_d;
  logic             early_q, early_d;
  logic             shown_q, shown_d;
  logic [TimeW-1:0] shown_time_q, shown_time_d;

  logic [TimeW-1:0] age;
  logic [TimeW-1:0] dbl;
  logic [TimeW-1:0] sev_ext;
  logic             rep, sev, trc;

  always_comb begin
    last_beat_d  = last_beat_q;
    fresh_d      = fresh_q;
    next_rep_d   = next_rep_q;
    stall_cnt_d  = stall_cnt_q;
    sev_cnt_d    = sev_cnt_q;
    stall_tot_d  = stall_tot_q;
    sev_tot_d    = sev_tot_q;
    worst_d      = worst_q;
    early_d      = early_q;
    shown_d      = shown_q;
    shown_time_d = shown_time_q;
    rep          = 1'b0;
    sev          = 1'b0;
    trc          = 1'b0;
    age          = '0;
    sev_ext      = {{(TimeW-ThrW){1'b0}}, thr_i.severe};
    dbl          = '0;

    case (item_i.kind)
      KIND_BEAT: begin
        last_beat_d = item_i.now_ms;
        fresh_d     = 1'b1;
      end
      KIND_SHOWN: begin
        shown_time_d = item_i.now_ms;
        shown_d      = 1'b1;
      end
      KIND_SAMPLE: begin
        age = item_i.now_ms - last_beat_q;
        if (fresh_q) begin
          // Re-arm the episode
          fresh_d     = 1'b0;
          next_rep_d  = {{(TimeW-ThrW){1'b0}}, thr_i.report};
          stall_cnt_d = 1'b0;
          sev_cnt_d   = 1'b0;
        end else if (age >= next_rep_q) begin
          rep = 1'b1;
          if (!stall_cnt_q) begin
            stall_cnt_d = 1'b1;
            stall_tot_d = (&stall_tot_q) ? stall_tot_q : stall_tot_q + 1'b1;
          end
          sev = (age >= sev_ext);
          if (sev && !sev_cnt_q) begin
            sev_cnt_d = 1'b1;
            sev_tot_d = (&sev_tot_q) ? sev_tot_q : sev_tot_q + 1'b1;
          end
          if (age > worst_q) begin
            worst_d = age;
            early_d = !shown_q || (last_beat_q < shown_time_q);
          end
          trc = (age >= {{(TimeW-ThrW){1'b0}}, thr_i.trace});
          // Double the age, saturate, and hold at severe until severe is seen
          dbl = age[TimeW-1] ? '1 : {age[TimeW-2:0], 1'b0};
          if (!sev_cnt_d && (dbl > sev_ext)) begin
            next_rep_d = sev_ext;
          end else begin
            next_rep_d = dbl;
          end
        end
      end
      default: ;
    endcase

    res_o.reported            = rep;
    res_o.stall_age_ms        = age;
    res_o.is_severe           = sev;
    res_o.trace_due           = trc;
    res_o.stall_total         = stall_tot_d;
    res_o.severe_total        = sev_tot_d;
    res_o.worst_age_ms        = worst_d;
    res_o.worst_before_window = early_d;
    res_o.window_is_shown     = shown_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_beat_q  <= '0;
      fresh_q      <= 1'b0;
      next_rep_q   <= {{(TimeW-ThrW){1'b0}}, ReportRst};
      stall_cnt_q  <= 1'b0;
      sev_cnt_q    <= 1'b0;
      stall_tot_q  <= '0;
      sev_tot_q    <= '0;
      worst_q      <= '0;
      early_q      <= 1'b0;
      shown_q      <= 1'b0;
      shown_time_q <= '0;
    end else if (en_i) begin
      last_beat_q  <= last_beat_d;
      fresh_q      <= fresh_d;
      next_rep_q   <= next_rep_d;
      stall_cnt_q  <= stall_cnt_d;
      sev_cnt_q    <= sev_cnt_d;
      stall_tot_q  <= stall_tot_d;
      sev_tot_q    <= sev_tot_d;
      worst_q      <= worst_d;
      early_q      <= early_d;
      shown_q      <= shown_d;
      shown_time_q <= shown_time_d;
    end
  end

endmodule

// ===== design/escalating_stall_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// escalating_stall_watchdog_unit: escalating stall watchdog, top level
// Input register, single-pass event update and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Events (heartbeat, window shown, monitor sample) arrive with a millisecond
//   timestamp on in_if; every event yields exactly one request on out_if with
//   the stall verdict of a sample and the running totals.
//   Thresholds are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle; index 0 report, 1 severe, 2 trace. Other indexes drop.
//   The event is first captured in the input register; the update lands in
//   the result register once that register is free or being drained, and
//   out_if presents the result from there.
//   Throughput: one event per cycle while out_if takes results; the rate is
//   set by the combinational state update (a 32-bit subtract, compares and a doubling).
//   Reset clears all episode state and counters, loads the default
//   thresholds (400, 5000, 2000 ms) and empties both registers.
//   When the receiver stalls, the result register holds its request; the
//   input register still fills, then in_if.ready falls until out_if drains.
// ----------------------------------------------------------------------------
module escalating_stall_watchdog_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  esw_in_if.sink                        in_if,
  esw_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [esw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [esw_pkg::ThrW-1:0]      cfg_wdata_i
);
  import esw_pkg::*;

  esw_thr_t thr;
  esw_in_t  item_q;
  logic     item_v_q;
  esw_out_t res_d, res_q;
  logic     res_v_q;
  logic     advance;

  esw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  // Move the held event into the result register when that slot is free
  assign advance     = item_v_q && (!res_v_q || out_if.ready);
  assign in_if.ready = !item_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_if.ready) begin
      item_v_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q <= in_if.data;
    end
  end

  esw_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .thr_i  (thr),
    .res_o  (res_d)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (advance) begin
      res_v_q <= 1'b1;
    end else if (out_if.ready) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid = res_v_q;
  assign out_if.data  = res_q;

endmodule
